>>> rtl/spectrum_band_level_meter_defines.svh
// assertion macros shared by the checker
`ifndef SPECTRUM_BAND_LEVEL_METER_DEFINES_SVH
`define SPECTRUM_BAND_LEVEL_METER_DEFINES_SVH
// antecedent implies consequent in the same cycle
`define SBLM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define SBLM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> rtl/sblm_pkg.sv
// shared constants and the helper function of the band level meter
package sblm_pkg;
	localparam int MAX_BARS = 64;
	localparam int MAX_BINS = 4096;
	localparam int SEGMENTS = 14;
	localparam int NUM_W    = 36;
	localparam int DEN_W    = 13;
	localparam int X_W      = 25;
	localparam int LOGQ_W   = 21;
	localparam logic [16:0] LOG_K = 17'd105218;
	localparam logic [24:0] EPS_Q = 25'd8;

	localparam logic [1:0] REG_BINS   = 2'd0;
	localparam logic [1:0] REG_BARS   = 2'd1;
	localparam logic [1:0] REG_ATTACK = 2'd2;
	localparam logic [1:0] REG_DECAY  = 2'd3;

	// count of n in 1..SEGMENTS with (256n-128)^2 <= SEGMENTS^2*level
	function automatic logic [5:0] lit_count(input logic [15:0] level);
		logic [31:0] v;
		logic [31:0] t;
		logic [5:0]  lit;
		v   = 32'(SEGMENTS * SEGMENTS) * {16'd0, level};
		lit = '0;
		for (int n = 1; n <= SEGMENTS; n++) begin
			t = 32'((n * 256 - 128) * (n * 256 - 128));
			if (t <= v) lit = 6'(n);
		end
		return lit;
	endfunction
endpackage

>>> rtl/spectrum_band_level_meter.sv
// band level meter top: bin accumulation, level memory and result register
//
// channel   direction  handshake            payload
// in        sink       in_valid/in_stall    magnitude, frame_start
// out       source     out_valid/out_stall  bar_index, bar_level, lit_segments, last_bar
// cfg       apb        psel/penable/pready  paddr, pwdata, prdata
//
// a bin that does not close its bar waits on the 36-step serial divider that finds the
// bar end; a bin past the final bar is taken without the divider
// a closing bin then runs the divider again for the average, up to 21 normalize shifts
// and the 16 squaring steps of the log, then the target, mix and emit states
// reset clears counters, state, out_valid and level valid bits and loads the config defaults at once; no clearing pass
// a stalled result waits in the output register while the next bin is taken
module spectrum_band_level_meter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [23:0] magnitude,
	input  logic        frame_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  bar_index,
	output logic [15:0] bar_level,
	output logic [5:0]  lit_segments,
	output logic        last_bar,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sblm_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_END  = 3'd1;
	localparam logic [2:0] S_AVG  = 3'd2;
	localparam logic [2:0] S_LOG  = 3'd3;
	localparam logic [2:0] S_TGT  = 3'd4;
	localparam logic [2:0] S_MIX  = 3'd5;
	localparam logic [2:0] S_EMIT = 3'd6;

	// configuration
	logic [12:0] num_bins_q;
	logic [6:0]  num_bars_q;
	logic [8:0]  attack_q;
	logic [8:0]  decay_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bins_q <= 13'd512;
			num_bars_q <= 7'd32;
			attack_q   <= 9'd154;
			decay_q    <= 9'd26;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_BINS:   num_bins_q <= pwdata[12:0];
				REG_BARS:   num_bars_q <= pwdata[6:0];
				REG_ATTACK: attack_q   <= pwdata[8:0];
				REG_DECAY:  decay_q    <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_BINS:   prdata = {19'd0, num_bins_q};
			REG_BARS:   prdata = {25'd0, num_bars_q};
			REG_ATTACK: prdata = {23'd0, attack_q};
			REG_DECAY:  prdata = {23'd0, decay_q};
			default:    prdata = '0;
		endcase
	end

	logic [12:0] bins_eff;
	logic [6:0]  bars_eff;
	logic [6:0]  bars_sat;

	always_comb begin
		bins_eff = num_bins_q;
		if (bins_eff == 13'd0) bins_eff = 13'd1;
		if (bins_eff > 13'(MAX_BINS)) bins_eff = 13'(MAX_BINS);
		bars_sat = num_bars_q;
		if (bars_sat == 7'd0) bars_sat = 7'd1;
		if (bars_sat > 7'(MAX_BARS)) bars_sat = 7'(MAX_BARS);
		bars_eff = ({6'd0, bars_sat} > bins_eff) ? bins_eff[6:0] : bars_sat;
	end

	// control and band state
	logic [2:0]  st_q;
	logic [6:0]  bar_pos_q;
	logic [12:0] bin_pos_q;
	logic [35:0] sum_q;
	logic [12:0] cnt_q;
	logic        in_acc;

	assign in_stall = (st_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;

	logic [6:0]  bp_base;
	logic [12:0] bin_base;
	logic [35:0] sum_base;
	logic [12:0] cnt_base;
	logic [19:0] end_num;

	always_comb begin
		bp_base  = frame_start ? 7'd0 : bar_pos_q;
		bin_base = frame_start ? 13'd0 : bin_pos_q;
		sum_base = frame_start ? 36'd0 : sum_q;
		cnt_base = frame_start ? 13'd0 : cnt_q;
		end_num  = 20'(({13'd0, bp_base} + 20'd1) * {7'd0, bins_eff});
	end

	// shared divider
	logic                div_start;
	logic [NUM_W-1:0]    div_num;
	logic [DEN_W-1:0]    div_den;
	logic                div_done;
	logic [NUM_W-1:0]    div_quot;
	logic                band_open;

	assign band_open = in_acc && (bp_base < bars_eff);
	assign div_start = band_open || (st_q == S_END && div_done && !(bin_pos_q < div_quot[12:0]));
	assign div_num   = (st_q == S_IDLE) ? {16'd0, end_num} : sum_q;
	assign div_den   = (st_q == S_IDLE) ? {6'd0, bars_eff} : cnt_q;

	sblm_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	// log unit
	logic              log_start;
	logic              log_done;
	logic [LOGQ_W-1:0] log2q;

	assign log_start = (st_q == S_AVG) && div_done;

	sblm_log2 u_log (
		.clk   (clk),
		.arst_n(arst_n),
		.start (log_start),
		.x     ({1'b0, div_quot[23:0]} + EPS_Q),
		.done  (log_done),
		.log2q (log2q)
	);

	// level memory with valid bits
	logic [15:0]         lvl_mem [MAX_BARS];
	logic [MAX_BARS-1:0] lvl_vld_q;
	logic [15:0]         lvl_rd_q;
	logic                rd_vld_q;
	logic                lvl_we;
	logic [15:0]         new_lvl;

	assign lvl_we = (st_q == S_MIX);

	always_ff @(posedge clk) begin
		if (lvl_we) lvl_mem[bar_pos_q[5:0]] <= new_lvl;
		lvl_rd_q <= lvl_mem[bar_pos_q[5:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (lvl_we) lvl_vld_q[bar_pos_q[5:0]] <= 1'b1;
			rd_vld_q <= lvl_vld_q[bar_pos_q[5:0]];
		end
	end

	// level arithmetic
	logic signed [21:0] l_val;
	logic signed [39:0] prod_s1;
	logic signed [39:0] u_val;
	logic [40:0]        n_val;
	logic [15:0]        target_q;
	logic [15:0]        new_lvl_q;
	logic [15:0]        old_lvl;
	logic [8:0]         g_sel;
	logic [9:0]         g_sat;
	logic signed [16:0] diff;
	logic signed [26:0] mix;

	assign l_val   = $signed({1'b0, log2q}) - 22'sd1507328;
	assign u_val   = 40'sh10_0000_0000 + prod_s1;
	assign n_val   = {1'b0, u_val} + 41'd524288;
	assign old_lvl = rd_vld_q ? lvl_rd_q : 16'd0;
	assign g_sel   = (target_q > old_lvl) ? attack_q : decay_q;
	assign g_sat   = (g_sel > 9'd256) ? 10'd256 : {1'b0, g_sel};
	assign diff    = $signed({1'b0, target_q}) - $signed({1'b0, old_lvl});
	assign mix     = $signed({3'b0, old_lvl, 8'd0}) + diff * $signed({1'b0, g_sat})
		+ 27'sd128;
	assign new_lvl = mix[23:8];

	// output register
	logic        out_valid_q;
	logic [5:0]  bar_index_q;
	logic [15:0] bar_level_q;
	logic [5:0]  lit_q;
	logic        last_q;
	logic        out_load;

	assign out_load = (st_q == S_EMIT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			bar_pos_q   <= '0;
			bin_pos_q   <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						bar_pos_q <= bp_base;
						if (band_open) begin
							bin_pos_q <= bin_base + 13'd1;
							sum_q     <= sum_base + {12'd0, magnitude};
							cnt_q     <= cnt_base + 13'd1;
							st_q      <= S_END;
						end else begin
							bin_pos_q <= bin_base;
							sum_q     <= sum_base;
							cnt_q     <= cnt_base;
						end
					end
				end
				S_END: begin
					if (div_done) st_q <= (bin_pos_q < div_quot[12:0]) ? S_IDLE : S_AVG;
				end
				S_AVG: begin
					if (div_done) st_q <= S_LOG;
				end
				S_LOG: begin
					if (log_done) st_q <= S_TGT;
				end
				S_TGT: st_q <= S_MIX;
				S_MIX: st_q <= S_EMIT;
				S_EMIT: begin
					if (out_load) begin
						bar_pos_q   <= bar_pos_q + 7'd1;
						sum_q       <= '0;
						cnt_q       <= '0;
						st_q        <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_LOG && log_done) prod_s1 <= l_val * $signed({1'b0, LOG_K});
		if (st_q == S_TGT) begin
			if (u_val <= 40'sd0) target_q <= 16'd0;
			else if (n_val[40:20] > 21'd65535) target_q <= 16'hFFFF;
			else target_q <= n_val[35:20];
		end
		if (lvl_we) new_lvl_q <= new_lvl;
		if (out_load) begin
			bar_index_q <= bar_pos_q[5:0];
			bar_level_q <= new_lvl_q;
			lit_q       <= lit_count(new_lvl_q);
			last_q      <= (bar_pos_q + 7'd1) == bars_eff;
		end
	end

	assign out_valid    = out_valid_q;
	assign bar_index    = bar_index_q;
	assign bar_level    = bar_level_q;
	assign lit_segments = lit_q;
	assign last_bar     = last_q;
endmodule

>>> rtl/sblm_div.sv
// restoring serial divider, one quotient bit per cycle
module sblm_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sblm_pkg::NUM_W-1:0] num,
	input  logic [sblm_pkg::DEN_W-1:0] den,
	output logic                      done,
	output logic [sblm_pkg::NUM_W-1:0] quot
);
	import sblm_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [5:0]       cnt_q;
	logic [NUM_W-1:0] q_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_sh;
	logic             fits;

	assign rem_sh = {rem_q, q_q[NUM_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 6'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			q_q   <= {q_q[NUM_W-2:0], fits};
			rem_q <= fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = q_q;
endmodule

>>> rtl/sblm_log2.sv
// log2 in q.16: serial normalize, then 16 squaring steps
module sblm_log2 (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sblm_pkg::X_W-1:0]    x,
	output logic                        done,
	output logic [sblm_pkg::LOGQ_W-1:0] log2q
);
	import sblm_pkg::*;

	localparam logic [1:0] L_IDLE = 2'd0;
	localparam logic [1:0] L_NORM = 2'd1;
	localparam logic [1:0] L_MUL  = 2'd2;
	localparam logic [1:0] L_SQ   = 2'd3;

	logic [1:0]  st_q;
	logic        done_q;
	logic [3:0]  it_q;
	logic [4:0]  p_q;
	logic [15:0] frac_q;
	logic [30:0] m_q;
	logic [61:0] prod_s1;
	logic [31:0] m2;

	assign m2 = prod_s1[61:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= L_IDLE;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				L_IDLE: begin
					if (start) st_q <= L_NORM;
				end
				L_NORM: begin
					if (m_q[30]) begin
						st_q <= L_MUL;
						it_q <= '0;
					end
				end
				L_MUL: st_q <= L_SQ;
				L_SQ: begin
					if (it_q == 4'd15) begin
						st_q   <= L_IDLE;
						done_q <= 1'b1;
					end else begin
						st_q <= L_MUL;
						it_q <= it_q + 4'd1;
					end
				end
				default: st_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			L_IDLE: begin
				if (start) begin
					m_q    <= {x, 6'd0};
					p_q    <= 5'd24;
					frac_q <= '0;
				end
			end
			L_NORM: begin
				if (!m_q[30]) begin
					m_q <= {m_q[29:0], 1'b0};
					p_q <= p_q - 5'd1;
				end
			end
			L_MUL: prod_s1 <= m_q * m_q;
			L_SQ: begin
				if (m2[31]) begin
					m_q    <= m2[31:1];
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					m_q    <= m2[30:0];
					frac_q <= {frac_q[14:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	assign done  = done_q;
	assign log2q = {p_q, frac_q};
endmodule

>>> rtl/sblm_checker.sv
// port checker for the band level meter and its bind
`include "spectrum_band_level_meter_defines.svh"
module sblm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [5:0]  bar_index,
	input logic [15:0] bar_level,
	input logic [5:0]  lit_segments,
	input logic        last_bar
);
	import sblm_pkg::*;

	// a stalled result beat holds
	`SBLM_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(bar_index) && $stable(bar_level) && $stable(lit_segments) && $stable(last_bar))
	// lit count never exceeds the segment count
	`SBLM_ASSERT_NOW(a_lit_max, out_valid, lit_segments <= 6'(SEGMENTS))
	// a new result never appears right after a bin is taken
	`SBLM_ASSERT_NEXT(a_no_quick, in_valid && !in_stall, !$rose(out_valid))
endmodule

bind spectrum_band_level_meter sblm_checker u_sblm_checker (.*);
